### rtl/curve_finite_difference_derivs_core_assert.svh
// assertion macros for the derivatives core
`ifndef CURVE_FINITE_DIFFERENCE_DERIVS_CORE_ASSERT_SVH
`define CURVE_FINITE_DIFFERENCE_DERIVS_CORE_ASSERT_SVH

// same-cycle implication on clk, disabled in reset
`define CFD_ASSERT_IMP(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// next-cycle implication on clk, disabled in reset
`define CFD_ASSERT_NXT(lbl, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

### rtl/cfd_pkg.sv
package cfd_pkg;

  localparam int SAMPLES    = 16;
  localparam int MAX_ORDERS = 4;
  localparam int IDX_W      = 4;
  localparam int CNT_W      = $clog2(SAMPLES + 1);
  localparam int ORD_W      = 2;
  localparam int OC_W       = 3;

  // register indexes of the configuration port
  localparam logic [1:0] CFG_ORDER_COUNT  = 2'd0;
  localparam logic [1:0] CFG_CLOSED_CURVE = 2'd1;
  localparam logic [1:0] CFG_INVERSE_STEP = 2'd2;

  typedef logic [31:0] coord_t;
  // element 0 is x, 1 is y, 2 is z
  typedef coord_t [2:0] vec_t;
  typedef vec_t [MAX_ORDERS-1:0] plane_t;

  typedef struct packed {
    logic             rot;
    logic             load;
    logic             wr;
    logic [ORD_W-1:0] wr_plane;
  } cell_ctrl_t;

endpackage

### rtl/cfd_cell.sv
module cfd_cell (
  input  logic                clk,
  input  cfd_pkg::cell_ctrl_t ctrl,
  input  cfd_pkg::vec_t       load_vec,
  input  cfd_pkg::vec_t       wr_vec,
  input  cfd_pkg::plane_t     ring_in,
  output cfd_pkg::plane_t     planes
);
  import cfd_pkg::*;

  // one sample: all derivative orders, shifted along the ring
  always_ff @(posedge clk) begin
    if (ctrl.rot) begin
      planes <= ring_in;
    end else begin
      if (ctrl.load) begin
        planes[0] <= load_vec;
      end
      if (ctrl.wr) begin
        planes[ctrl.wr_plane] <= wr_vec;
      end
    end
  end

endmodule

### rtl/cfd_scale.sv
module cfd_scale (
  input  logic            clk,
  input  cfd_pkg::coord_t a,
  input  cfd_pkg::coord_t b,
  input  logic            shift17,
  input  logic [31:0]     inverse_step,
  output cfd_pkg::coord_t result,
  output logic            sat
);
  import cfd_pkg::*;

  logic signed [32:0] diff;
  logic [32:0]        mag;
  logic               neg;
  logic               sh1;
  logic [48:0]        hi;
  logic [48:0]        lo;
  logic               neg2;
  logic               sh2;
  logic [49:0]        sum;
  logic [33:0]        r;
  logic               hi_ovf;

  // stage 1: difference and magnitude
  assign diff = {a[31], a} - {b[31], b};
  always_ff @(posedge clk) begin
    neg <= diff[32];
    mag <= diff[32] ? 33'(-diff) : 33'(diff);
    sh1 <= shift17;
  end

  // stage 2: two partial products
  always_ff @(posedge clk) begin
    hi   <= 49'(mag * inverse_step[31:16]);
    lo   <= 49'(mag * inverse_step[15:0]);
    neg2 <= neg;
    sh2  <= sh1;
  end

  // combine, round half away from zero, saturate
  always_comb begin
    hi_ovf = |hi[48:32];
    sum = {2'b00, hi[31:0], 16'h0000} + {1'b0, lo}
        + (sh2 ? 50'h1_0000 : 50'h0_8000);
    r = sh2 ? 34'(sum >> 17) : 34'(sum >> 16);
    if (neg2) begin
      sat    = hi_ovf || (r > 34'h0_8000_0000);
      result = sat ? 32'h8000_0000 : 32'(-r);
    end else begin
      sat    = hi_ovf || (r > 34'h0_7FFF_FFFF);
      result = sat ? 32'h7FFF_FFFF : r[31:0];
    end
  end

endmodule

### rtl/curve_finite_difference_derivs_core.sv
// Finite-difference derivatives of a sampled 3D curve, Q16.16.
// Input channel (in_valid/in_ready): one sample word per cycle while loading;
// in_ready is high only in the load phase. A word with last_sample starts the
// compute pass; words beyond 16 samples are dropped and flag overflow.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready:
// index 0 order_count, 1 closed_curve, 2 inverse_step.
// Compute: the samples sit in a ring of cells; each derivative order walks
// the ring once, in four steps per sample (rotate, difference, multiply,
// finish) on three shared scaling lanes; a single sample, where there is
// nothing to rotate, skips the rotate step.
// Output channel (out_valid/out_ready): n*orders words, sample-major, one per
// cycle while the receiver takes them; last_result marks the final word.
// A stalled receiver holds the output register and pauses the emission.
// The first result word is registered from the emit state, which follows the
// last finish step of the pass, or the last sample when only order 0 is sent.
// Reset clears the control state and sets order_count 2, closed_curve 0,
// inverse_step 1.0; stored samples are not cleared.
module curve_finite_difference_derivs_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [31:0]         x_in,
  input  logic signed [31:0]         y_in,
  input  logic signed [31:0]         z_in,
  input  logic                       last_sample,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [cfd_pkg::IDX_W-1:0]  sample_index,
  output logic [cfd_pkg::ORD_W-1:0]  deriv_order,
  output logic signed [31:0]         x_out,
  output logic signed [31:0]         y_out,
  output logic signed [31:0]         z_out,
  output logic                       last_result,
  output logic                       overflow_flag,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data
);
  import cfd_pkg::*;

  `include "curve_finite_difference_derivs_core_assert.svh"

  typedef enum logic [5:0] {
    S_LOAD  = 6'b000001,
    S_ROT   = 6'b000010,
    S_ISSUE = 6'b000100,
    S_MUL   = 6'b001000,
    S_FIN   = 6'b010000,
    S_EMIT  = 6'b100000
  } state_t;

  localparam int POS2 = 2 % SAMPLES;

  state_t           state;
  logic [OC_W-1:0]  order_count;
  logic             closed_curve;
  logic [31:0]      inverse_step;
  logic [CNT_W-1:0] sample_count;
  logic             overflow_seen;
  logic [CNT_W-1:0] n;
  logic [OC_W-1:0]  orders;
  logic [IDX_W-1:0] i;
  logic [ORD_W-1:0] u;
  vec_t             lasthead;
  vec_t             endvec;

  logic             in_fire;
  logic             emit_fire;
  logic             emit_last;
  logic             rotate;
  logic             fin_write;
  logic [ORD_W-1:0] pu;
  logic [ORD_W-1:0] orders_last;
  logic             at_first;
  logic             at_last;
  logic             n_one;
  logic             reuse_end;
  logic [CNT_W-1:0] cnt_after;
  logic [OC_W-1:0]  oc_clamp;
  vec_t             head;
  vec_t             pos1;
  vec_t             pos2;
  vec_t             op_a;
  vec_t             op_b;
  logic             op_sh17;
  vec_t             lane_res;
  logic [2:0]       lane_sat;
  vec_t             wr_vec;
  vec_t             load_vec;

  plane_t           cell_planes [SAMPLES];
  cell_ctrl_t       cell_ctrl   [SAMPLES];

  assign in_ready  = (state == S_LOAD);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;

  assign pu          = u - 1'b1;
  assign orders_last = ORD_W'(orders - 1'b1);
  assign at_first    = (i == '0);
  assign at_last     = ({1'b0, i} == n - 1'b1);
  assign n_one       = (n == CNT_W'(1));
  assign reuse_end   = at_first && closed_curve;
  assign emit_fire   = (state == S_EMIT) && (!out_valid || out_ready);
  assign emit_last   = (u == orders_last) && at_last;
  assign rotate      = (state == S_ROT) || (emit_fire && (u == orders_last));
  assign fin_write   = (state == S_FIN);
  assign load_vec    = {z_in, y_in, x_in};

  // count after this word and clamped order count
  always_comb begin
    cnt_after = (sample_count < CNT_W'(SAMPLES)) ? sample_count + 1'b1 : sample_count;
    if (order_count == '0) begin
      oc_clamp = OC_W'(1);
    end else if (order_count > OC_W'(MAX_ORDERS)) begin
      oc_clamp = OC_W'(MAX_ORDERS);
    end else begin
      oc_clamp = order_count;
    end
  end

  // ring of sample cells
  for (genvar j = 0; j < SAMPLES; j++) begin : g_cell
    localparam int NEXT = (j + 1) % SAMPLES;
    plane_t ring_in;
    assign ring_in = (CNT_W'(j) == n - 1'b1) ? cell_planes[0] : cell_planes[NEXT];
    assign cell_ctrl[j] = '{rot:      rotate,
                            load:     in_fire && (sample_count == CNT_W'(j)),
                            wr:       fin_write && (j == 0),
                            wr_plane: u};
    cfd_cell u_cell (
      .clk      (clk),
      .ctrl     (cell_ctrl[j]),
      .load_vec (load_vec),
      .wr_vec   (wr_vec),
      .ring_in  (ring_in),
      .planes   (cell_planes[j])
    );
  end

  // neighbor taps of the previous order
  assign head = cell_planes[0][pu];
  assign pos1 = cell_planes[1][pu];
  assign pos2 = cell_planes[POS2][pu];

  // difference operands for the sample at the head
  always_comb begin
    if (at_first) begin
      op_a = pos1;
      op_b = head;
      op_sh17 = 1'b0;
    end else if (at_last) begin
      op_b = lasthead;
      if (closed_curve) begin
        op_a = (n == CNT_W'(2)) ? head : pos2;
        op_sh17 = 1'b1;
      end else begin
        op_a = head;
        op_sh17 = 1'b0;
      end
    end else begin
      op_a = pos1;
      op_b = lasthead;
      op_sh17 = 1'b1;
    end
  end

  // one scaling lane per coordinate
  for (genvar k = 0; k < 3; k++) begin : g_lane
    cfd_scale u_scale (
      .clk          (clk),
      .a            (op_a[k]),
      .b            (op_b[k]),
      .shift17      (op_sh17),
      .inverse_step (inverse_step),
      .result       (lane_res[k]),
      .sat          (lane_sat[k])
    );
  end

  // value written back into the head cell
  always_comb begin
    if (n_one) begin
      wr_vec = '0;
    end else if (reuse_end) begin
      wr_vec = endvec;
    end else begin
      wr_vec = lane_res;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      order_count  <= OC_W'(2);
      closed_curve <= 1'b0;
      inverse_step <= 32'h0001_0000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ORDER_COUNT:  order_count  <= cfg_data[OC_W-1:0];
        CFG_CLOSED_CURVE: closed_curve <= cfg_data[0];
        CFG_INVERSE_STEP: inverse_step <= cfg_data;
        default: ;
      endcase
    end
  end

  // pass sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_LOAD;
      sample_count  <= '0;
      overflow_seen <= 1'b0;
      n             <= CNT_W'(1);
      orders        <= OC_W'(1);
      i             <= '0;
      u             <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            sample_count <= cnt_after;
            if (sample_count == CNT_W'(SAMPLES)) begin
              overflow_seen <= 1'b1;
            end
            if (last_sample) begin
              n      <= cnt_after;
              orders <= oc_clamp;
              i      <= '0;
              if (oc_clamp == OC_W'(1)) begin
                u     <= '0;
                state <= S_EMIT;
              end else begin
                u     <= ORD_W'(1);
                state <= (cnt_after == CNT_W'(1)) ? S_ISSUE : S_ROT;
              end
            end
          end
        end
        S_ROT: begin
          i     <= at_last ? '0 : i + 1'b1;
          state <= S_ISSUE;
        end
        S_ISSUE: state <= S_MUL;
        S_MUL:   state <= S_FIN;
        S_FIN: begin
          if (!n_one && !reuse_end && (|lane_sat)) begin
            overflow_seen <= 1'b1;
          end
          if (at_first) begin
            if (u == orders_last) begin
              u     <= '0;
              state <= S_EMIT;
            end else begin
              u     <= u + 1'b1;
              state <= n_one ? S_ISSUE : S_ROT;
            end
          end else begin
            state <= S_ROT;
          end
        end
        S_EMIT: begin
          if (emit_fire) begin
            if (u == orders_last) begin
              u <= '0;
              if (at_last) begin
                i             <= '0;
                sample_count  <= '0;
                overflow_seen <= 1'b0;
                state         <= S_LOAD;
              end else begin
                i <= i + 1'b1;
              end
            end else begin
              u <= u + 1'b1;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // previous-order neighbor and shared closed-curve end
  always_ff @(posedge clk) begin
    if (state == S_ROT) begin
      lasthead <= head;
    end
    if (fin_write && at_last && closed_curve && !n_one) begin
      endvec <= lane_res;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      sample_index  <= i;
      deriv_order   <= u;
      x_out         <= cell_planes[0][u][0];
      y_out         <= cell_planes[0][u][1];
      z_out         <= cell_planes[0][u][2];
      last_result   <= emit_last;
      overflow_flag <= overflow_seen;
    end
  end

  `CFD_ASSERT_IMP(a_head_in_range, state != S_LOAD, {1'b0, i} < n, "head index past sample count")
  `CFD_ASSERT_NXT(a_run_ends, emit_fire && emit_last, (state == S_LOAD) && (sample_count == '0), "run did not return to load")
  `CFD_ASSERT_NXT(a_pass_to_emit, (state == S_FIN) && at_first && (u == orders_last), state == S_EMIT, "pass end did not start emit")
  `CFD_ASSERT_NXT(a_drop_flags, in_fire && (sample_count == CNT_W'(SAMPLES)), overflow_seen, "dropped word not flagged")

endmodule
